// ===== src/stbl_pkg.sv =====
package stbl_pkg;

	// Table geometry
	localparam int TABLE_DEPTH = 1024;
	localparam int DATA_WIDTH  = 32;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int COUNT_W     = ADDR_W + 1;

	typedef logic [ADDR_W-1:0]            addr_t;
	typedef logic [COUNT_W-1:0]           count_t;
	typedef logic signed [DATA_WIDTH-1:0] data_t;

	localparam count_t DEPTH_COUNT = COUNT_W'(TABLE_DEPTH);

	// Operation codes
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// Search modes
	localparam logic MODE_LOWER = 1'b0;
	localparam logic MODE_UPPER = 1'b1;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SEARCH_MODE = 2'd1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_VALUE
	} srch_state_t;

	// Table write request
	typedef struct packed {
		logic  en;
		addr_t addr;
		data_t coord;
		data_t value;
	} tbl_wr_t;

	// Table read requests
	typedef struct packed {
		logic  coord_en;
		addr_t coord_addr;
		logic  value_en;
		addr_t value_addr;
	} tbl_rd_t;

	// Search result
	typedef struct packed {
		count_t position;
		data_t  value;
		logic   empty;
	} srch_res_t;

endpackage

// ===== src/stbl_table.sv =====
module stbl_table (
	input  logic             clk,
	input  stbl_pkg::tbl_wr_t wr,
	input  stbl_pkg::tbl_rd_t rd,
	output stbl_pkg::data_t   coord_rdata,
	output stbl_pkg::data_t   value_rdata
);

	stbl_pkg::data_t coord_mem [stbl_pkg::TABLE_DEPTH];
	stbl_pkg::data_t value_mem [stbl_pkg::TABLE_DEPTH];

	// Write both stores at one address; contents are undefined until written
	always_ff @(posedge clk) begin
		if (wr.en) begin
			coord_mem[wr.addr] <= wr.coord;
			value_mem[wr.addr] <= wr.value;
		end
	end

	// Read coordinates; data holds when no read is issued
	always_ff @(posedge clk) begin
		if (rd.coord_en) begin
			coord_rdata <= coord_mem[rd.coord_addr];
		end
	end

	// Read values; data holds until the result is taken
	always_ff @(posedge clk) begin
		if (rd.value_en) begin
			value_rdata <= value_mem[rd.value_addr];
		end
	end

endmodule

// ===== src/stbl_search.sv =====
module stbl_search (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  stbl_pkg::data_t     key,
	input  stbl_pkg::count_t    n,
	input  logic                mode,
	output logic                idle,
	output stbl_pkg::tbl_rd_t   rd,
	input  stbl_pkg::data_t     coord_rdata,
	input  stbl_pkg::data_t     value_rdata,
	output logic                res_valid,
	input  logic                res_ready,
	output stbl_pkg::srch_res_t res
);

	stbl_pkg::srch_state_t state_q, state_nxt;
	stbl_pkg::count_t      lo_q, len_q, mid_q;
	stbl_pkg::data_t       key_q;
	logic                  mode_q;
	logic                  empty_q;

	stbl_pkg::count_t half, lo_nxt, len_nxt, mid_nxt, pick, half_n;
	logic             right;

	// Probe step: compare the fetched coordinate and narrow the window
	always_comb begin
		half_n = n >> 1;
		half = len_q >> 1;
		if (mode_q == stbl_pkg::MODE_UPPER) begin
			right = coord_rdata <= key_q;
		end else begin
			right = coord_rdata < key_q;
		end
		if (right) begin
			lo_nxt  = mid_q + stbl_pkg::COUNT_W'(1);
			len_nxt = len_q - half - stbl_pkg::COUNT_W'(1);
		end else begin
			lo_nxt  = lo_q;
			len_nxt = half;
		end
		mid_nxt = lo_nxt + (len_nxt >> 1);
		pick    = (lo_nxt < n) ? lo_nxt : n - stbl_pkg::COUNT_W'(1);
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stbl_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state, memory reads and result handshake
	always_comb begin
		state_nxt     = state_q;
		idle          = 1'b0;
		res_valid     = 1'b0;
		rd.coord_en   = 1'b0;
		rd.coord_addr = mid_nxt[stbl_pkg::ADDR_W-1:0];
		rd.value_en   = 1'b0;
		rd.value_addr = pick[stbl_pkg::ADDR_W-1:0];
		unique case (state_q)
			stbl_pkg::S_IDLE: begin
				idle          = 1'b1;
				rd.coord_addr = half_n[stbl_pkg::ADDR_W-1:0];
				if (start) begin
					if (n == '0) begin
						state_nxt = stbl_pkg::S_VALUE;
					end else begin
						rd.coord_en = 1'b1;
						state_nxt   = stbl_pkg::S_SEARCH;
					end
				end
			end
			stbl_pkg::S_SEARCH: begin
				if (len_nxt == '0) begin
					rd.value_en = 1'b1;
					state_nxt   = stbl_pkg::S_VALUE;
				end else begin
					rd.coord_en = 1'b1;
				end
			end
			stbl_pkg::S_VALUE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_nxt = stbl_pkg::S_IDLE;
				end
			end
			default: begin
				state_nxt = stbl_pkg::S_IDLE;
			end
		endcase
	end

	// Search window registers
	always_ff @(posedge clk) begin
		if (state_q == stbl_pkg::S_IDLE && start) begin
			lo_q    <= '0;
			len_q   <= n;
			mid_q   <= half_n;
			key_q   <= key;
			mode_q  <= mode;
			empty_q <= (n == '0);
		end else if (state_q == stbl_pkg::S_SEARCH) begin
			lo_q  <= lo_nxt;
			len_q <= len_nxt;
			mid_q <= mid_nxt;
		end
	end

	// Form the result; an empty table reads as position and value zero
	always_comb begin
		res.empty    = empty_q;
		res.position = empty_q ? '0 : lo_q;
		res.value    = empty_q ? '0 : value_rdata;
	end

endmodule

// ===== src/sorted_table_bound_lookup_top.sv =====
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  operation, entry_index, coordinate,
//                                           entry_value, search_key
// out       output     out_valid/out_stall  found_position, looked_up_value, table_empty
// cfg       input      cfg_write            cfg_index, cfg_data
//
// A query makes at most k = floor(log2(n)) + 1 probes for n entries in use, and no
// new transaction is accepted until its result has moved to the output register;
// each probe is one coordinate memory read. An empty-table query makes no memory
// reads. Reset clears control and configuration only; table contents stay
// undefined until loaded. A stalled result sits in the output register while
// the next transaction is accepted.
module sorted_table_bound_lookup_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               operation,
	input  stbl_pkg::addr_t                    entry_index,
	input  stbl_pkg::data_t                    coordinate,
	input  stbl_pkg::data_t                    entry_value,
	input  stbl_pkg::data_t                    search_key,
	output logic                               out_valid,
	input  logic                               out_stall,
	output stbl_pkg::count_t                   found_position,
	output stbl_pkg::data_t                    looked_up_value,
	output logic                               table_empty,
	input  logic                               cfg_write,
	input  logic [stbl_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  stbl_pkg::count_t                   cfg_data
);

	stbl_pkg::count_t    entry_count_q;
	logic                search_mode_q;
	stbl_pkg::count_t    n_sat;
	logic                in_accept;
	logic                srch_idle;
	logic                res_valid;
	logic                res_ready;
	stbl_pkg::srch_res_t res;
	stbl_pkg::tbl_wr_t   wr;
	stbl_pkg::tbl_rd_t   rd;
	stbl_pkg::data_t     coord_rdata;
	stbl_pkg::data_t     value_rdata;
	logic                out_valid_q;
	stbl_pkg::srch_res_t out_q;

	// Decode configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
			search_mode_q <= stbl_pkg::MODE_UPPER;
		end else if (cfg_write) begin
			unique case (cfg_index)
				stbl_pkg::REG_ENTRY_COUNT: entry_count_q <= cfg_data;
				stbl_pkg::REG_SEARCH_MODE: search_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Saturate the count to the table depth
	assign n_sat = (entry_count_q > stbl_pkg::DEPTH_COUNT) ? stbl_pkg::DEPTH_COUNT
	                                                     : entry_count_q;

	// Accept a transaction only while the search engine is idle
	assign in_stall  = !srch_idle;
	assign in_accept = in_valid && !in_stall;

	// Write a loaded entry; drop loads beyond the table
	always_comb begin
		wr.en    = in_accept && (operation == stbl_pkg::OP_LOAD) &&
		           (stbl_pkg::COUNT_W'(entry_index) < stbl_pkg::DEPTH_COUNT);
		wr.addr  = entry_index;
		wr.coord = coordinate;
		wr.value = entry_value;
	end

	stbl_table u_table (
		.clk         (clk),
		.wr          (wr),
		.rd          (rd),
		.coord_rdata (coord_rdata),
		.value_rdata (value_rdata)
	);

	stbl_search u_search (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (in_accept && (operation == stbl_pkg::OP_QUERY)),
		.key         (search_key),
		.n           (n_sat),
		.mode        (search_mode_q),
		.idle        (srch_idle),
		.rd          (rd),
		.coord_rdata (coord_rdata),
		.value_rdata (value_rdata),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res)
	);

	// Output register: load when empty or being drained
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid       = out_valid_q;
	assign found_position  = out_q.position;
	assign looked_up_value = out_q.value;
	assign table_empty     = out_q.empty;

	// An empty-table result reports position and value zero
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && table_empty |-> found_position == '0 && looked_up_value == '0)
		else $error("empty-table result carries nonzero fields");

	// A found position never exceeds the count in use
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> found_position <= n_sat)
		else $error("found position beyond entry count");

	// Any accepted query keeps the engine busy for the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && operation == stbl_pkg::OP_QUERY |=> in_stall)
		else $error("transaction accepted while a query is in flight");

	// Table writes only happen while no search is running
	assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> !rd.coord_en && !rd.value_en)
		else $error("table write overlaps a search read");

endmodule

// ===== bench/sorted_table_bound_lookup_top_test.sv =====
`timescale 1ns / 1ps

module sorted_table_bound_lookup_top_test;

	localparam int SETTLE_CYCLES = 20;
	localparam int QUIET_LIMIT   = 5000;
	localparam int HOLD_CYCLES   = 300;
	localparam int REPORT_MAX    = 10;

	localparam stbl_pkg::data_t COORD_MIN = {1'b1, {(stbl_pkg::DATA_WIDTH-1){1'b0}}};
	localparam stbl_pkg::data_t COORD_MAX = {1'b0, {(stbl_pkg::DATA_WIDTH-1){1'b1}}};

	// Register indexes past the end of the register list
	localparam logic [stbl_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [stbl_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           in_valid = 1'b0;
	logic                           in_stall;
	logic                           operation = stbl_pkg::OP_LOAD;
	stbl_pkg::addr_t                entry_index = '0;
	stbl_pkg::data_t                coordinate = '0;
	stbl_pkg::data_t                entry_value = '0;
	stbl_pkg::data_t                search_key = '0;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	stbl_pkg::count_t               found_position;
	stbl_pkg::data_t                looked_up_value;
	logic                           table_empty;
	logic                           cfg_write = 1'b0;
	logic [stbl_pkg::CFG_IDX_W-1:0] cfg_index = stbl_pkg::REG_ENTRY_COUNT;
	stbl_pkg::count_t               cfg_data = '0;

	// Predicted table contents and register copies
	stbl_pkg::data_t     coord_tbl [stbl_pkg::TABLE_DEPTH];
	stbl_pkg::data_t     value_tbl [stbl_pkg::TABLE_DEPTH];
	stbl_pkg::count_t    used_count = '0;
	logic                upper_mode = stbl_pkg::MODE_UPPER;
	stbl_pkg::srch_res_t pending_answers [$];

	int src_idle_pct = 0;
	int stall_pct = 0;
	bit hold_request = 1'b0;
	int mismatch_count = 0;
	int quiet_cycles = 0;

	sorted_table_bound_lookup_top DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.operation       (operation),
		.entry_index     (entry_index),
		.coordinate      (coordinate),
		.entry_value     (entry_value),
		.search_key      (search_key),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.found_position  (found_position),
		.looked_up_value (looked_up_value),
		.table_empty     (table_empty),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Binary search over the first active entries, as the block should do it
	function automatic stbl_pkg::srch_res_t bound_lookup(stbl_pkg::data_t key);
		stbl_pkg::srch_res_t r;
		int unsigned         n, lo, len, half, mid;
		logic                go_right;
		n = (used_count > stbl_pkg::DEPTH_COUNT) ? stbl_pkg::TABLE_DEPTH : int'(used_count);
		r.empty = (n == 0);
		r.position = '0;
		r.value = '0;
		if (n != 0) begin
			lo = 0;
			len = n;
			while (len > 0) begin
				half = len >> 1;
				mid = lo + half;
				if (upper_mode == stbl_pkg::MODE_UPPER)
					go_right = coord_tbl[stbl_pkg::addr_t'(mid)] <= key;
				else
					go_right = coord_tbl[stbl_pkg::addr_t'(mid)] < key;
				if (go_right) begin
					lo = mid + 1;
					len -= half + 1;
				end else begin
					len = half;
				end
			end
			r.position = stbl_pkg::count_t'(lo);
			r.value = value_tbl[stbl_pkg::addr_t'((lo < n) ? lo : n - 1)];
		end
		return r;
	endfunction

	// Offer one transaction, wait for acceptance, then update the prediction
	task automatic send_item(logic op, stbl_pkg::addr_t idx, stbl_pkg::data_t coord,
		stbl_pkg::data_t val, stbl_pkg::data_t key);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		operation   <= op;
		entry_index <= idx;
		coordinate  <= coord;
		entry_value <= val;
		search_key  <= key;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (op == stbl_pkg::OP_LOAD) begin
			coord_tbl[idx] = coord;
			value_tbl[idx] = val;
		end else begin
			pending_answers.push_back(bound_lookup(key));
		end
	endtask

	task automatic send_load(stbl_pkg::addr_t idx, stbl_pkg::data_t coord,
		stbl_pkg::data_t val);
		send_item(stbl_pkg::OP_LOAD, idx, coord, val, stbl_pkg::data_t'($urandom));
	endtask

	task automatic send_query(stbl_pkg::data_t key);
		send_item(stbl_pkg::OP_QUERY, stbl_pkg::addr_t'($urandom),
			stbl_pkg::data_t'($urandom), stbl_pkg::data_t'($urandom), key);
	endtask

	// Drop valid and hold until every predicted answer has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
	endtask

	// Write one register once the block has gone idle
	task automatic write_reg(logic [stbl_pkg::CFG_IDX_W-1:0] idx, stbl_pkg::count_t data);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_write <= 1'b0;
		if (idx == stbl_pkg::REG_ENTRY_COUNT)
			used_count = data;
		else if (idx == stbl_pkg::REG_SEARCH_MODE)
			upper_mode = data[0];
	endtask

	// Key close to a stored coordinate, with an occasional extreme or random one
	function automatic stbl_pkg::data_t pick_key(int span);
		int sel;
		sel = $urandom_range(15);
		if (sel == 0)
			return stbl_pkg::data_t'($urandom);
		if (sel == 1)
			return COORD_MIN;
		if (sel == 2)
			return COORD_MAX;
		return coord_tbl[stbl_pkg::addr_t'($urandom_range(span - 1))] +
			stbl_pkg::data_t'(int'($urandom_range(2)) - 1);
	endfunction

	task automatic test_empty_table();
		src_idle_pct = 0;
		stall_pct = 0;
		write_reg(stbl_pkg::REG_ENTRY_COUNT, '0);
		send_query(COORD_MIN);
		send_query(COORD_MAX);
		send_load(stbl_pkg::addr_t'(stbl_pkg::TABLE_DEPTH - 1), COORD_MAX, COORD_MIN);
		send_query(stbl_pkg::data_t'($urandom));
	endtask

	task automatic test_directed_bounds();
		stbl_pkg::data_t coords [8] = '{COORD_MIN, COORD_MIN, -5, 0, 0, 0, 7, COORD_MAX};
		stbl_pkg::data_t vals [8]   = '{COORD_MAX, COORD_MIN, 1, -1, 2, 3, 0, 100};
		for (int i = 0; i < 8; i++)
			send_load(stbl_pkg::addr_t'(i), coords[i], vals[i]);
		write_reg(stbl_pkg::REG_ENTRY_COUNT, stbl_pkg::count_t'(8));

		// Upper bound is the reset mode
		send_query(COORD_MIN);
		send_query(-6);
		send_query(0);
		send_query(COORD_MAX);

		write_reg(stbl_pkg::REG_SEARCH_MODE, stbl_pkg::count_t'(stbl_pkg::MODE_LOWER));
		send_query(COORD_MIN);
		send_query(0);
		send_query(COORD_MAX);
		send_query(8);

		// Single entry: key past it gives the count, value clamps to the entry
		write_reg(stbl_pkg::REG_ENTRY_COUNT, stbl_pkg::count_t'(1));
		send_query(COORD_MAX);
		send_query(COORD_MIN);

		// Writes past the register list leave count and mode alone
		write_reg(REG_SPARE_A, '1);
		write_reg(REG_SPARE_B, '1);
		send_query(COORD_MAX);
		send_query(COORD_MIN);
	endtask

	task automatic test_full_table();
		stbl_pkg::count_t sizes [4] = '{stbl_pkg::DEPTH_COUNT, '1,
			stbl_pkg::count_t'(stbl_pkg::TABLE_DEPTH + 1),
			stbl_pkg::count_t'(stbl_pkg::TABLE_DEPTH - 1)};
		longint acc;
		src_idle_pct = 0;
		stall_pct = 0;

		// Fill every entry in non-descending order with runs of duplicates
		acc = longint'(COORD_MIN);
		for (int i = 0; i < stbl_pkg::TABLE_DEPTH; i++) begin
			if (i != 0 && $urandom_range(3) != 0)
				acc += $urandom_range(1, 8000000);
			if (i == stbl_pkg::TABLE_DEPTH - 1 || acc > longint'(COORD_MAX))
				acc = longint'(COORD_MAX);
			send_load(stbl_pkg::addr_t'(i), stbl_pkg::data_t'(acc),
				stbl_pkg::data_t'($urandom));
		end

		// Full, saturated and one-short counts, both modes
		foreach (sizes[s]) begin
			write_reg(stbl_pkg::REG_ENTRY_COUNT, sizes[s]);
			for (int m = 0; m < 2; m++) begin
				write_reg(stbl_pkg::REG_SEARCH_MODE,
					{stbl_pkg::addr_t'($urandom_range(1023)), m[0]});
				repeat (20) send_query(pick_key(stbl_pkg::TABLE_DEPTH));
			end
		end
	endtask

	task automatic test_receiver_hold();
		src_idle_pct = 0;
		stall_pct = 0;
		// Keep offering queries while the result side holds off
		hold_request = 1'b1;
		repeat (40) send_query(pick_key(stbl_pkg::TABLE_DEPTH));
		wait_drained();
	endtask

	task automatic test_random_traffic(int src_pct, int dst_pct, int item_budget);
		int     sent;
		int     sel;
		int     n;
		int     span;
		longint acc;
		src_idle_pct = src_pct;
		stall_pct = dst_pct;
		sent = 0;
		while (sent < item_budget) begin
			// Pick a table size: mostly small, now and then empty, larger or saturated
			sel = $urandom_range(99);
			if (sel < 5)
				n = 0;
			else if (sel < 85)
				n = $urandom_range(1, 48);
			else if (sel < 95)
				n = $urandom_range(49, stbl_pkg::TABLE_DEPTH);
			else
				n = $urandom_range(stbl_pkg::TABLE_DEPTH + 1, 2047);
			write_reg(stbl_pkg::REG_ENTRY_COUNT, stbl_pkg::count_t'(n));
			write_reg(stbl_pkg::REG_SEARCH_MODE, stbl_pkg::count_t'($urandom));

			// Rebuild a small sorted prefix with close coordinates and duplicates
			if (n > 0 && n <= 48) begin
				acc = longint'(stbl_pkg::data_t'($urandom));
				for (int i = 0; i < n; i++) begin
					if ($urandom_range(7) == 0)
						acc += $urandom_range(1, 100000);
					else
						acc += $urandom_range(3);
					if (acc > longint'(COORD_MAX))
						acc = longint'(COORD_MAX);
					send_load(stbl_pkg::addr_t'(i), stbl_pkg::data_t'(acc),
						stbl_pkg::data_t'($urandom));
				end
				sent += n;
			end

			span = (n == 0) ? 8 : ((n > stbl_pkg::TABLE_DEPTH) ? stbl_pkg::TABLE_DEPTH : n);
			repeat ($urandom_range(10, 40)) begin
				// Mostly queries; some stray loads anywhere, which may unsort the table
				if ($urandom_range(99) < 15)
					send_load(stbl_pkg::addr_t'($urandom), stbl_pkg::data_t'($urandom),
						stbl_pkg::data_t'($urandom));
				else
					send_query(pick_key(span));
				sent++;
			end
		end
	endtask

	task automatic flag_mismatch(string field, longint want, longint got);
		mismatch_count++;
		if (mismatch_count <= REPORT_MAX)
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
	endtask

	// Check each accepted result against the oldest predicted answer
	task automatic check_answer();
		stbl_pkg::srch_res_t want;
		if (pending_answers.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= REPORT_MAX)
				$display("%0t: unexpected result, position %0d value %0d empty %0b",
					$time, found_position, looked_up_value, table_empty);
		end else begin
			want = pending_answers.pop_front();
			if (found_position !== want.position)
				flag_mismatch("found_position", want.position, found_position);
			if (looked_up_value !== want.value)
				flag_mismatch("looked_up_value", want.value, looked_up_value);
			if (table_empty !== want.empty)
				flag_mismatch("table_empty", want.empty, table_empty);
		end
	endtask

	// Check results and drive the result-side stall, with a long hold on request
	always @(posedge clk) begin
		static int hold_left = 0;
		if (arst_n && out_valid && !out_stall)
			check_answer();
		if (hold_request) begin
			hold_left = HOLD_CYCLES;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// End the run when no transaction moves for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_directed_bounds();
		test_full_table();
		test_receiver_hold();
		test_random_traffic(0, 0, 180);
		test_random_traffic(47, 0, 180);
		test_random_traffic(0, 47, 180);
		test_random_traffic(30, 30, 180);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_answers.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
